@@ design/lpss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the LED pattern sequencer and serialiser.
// No dependencies; used by lpss_shifter and led_pattern_sequencer_serializer_top.
package lpss_pkg;

    localparam int MAX_ELEMENTS_DEF       = 32;
    localparam int MAX_SCENARIO_COUNT_DEF = 16;
    localparam int FRAME_GROUP_BITS       = 32;

    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_WR_PATTERN = 2'd1;
    localparam logic [1:0] OP_WR_COUNTS  = 2'd2;

    localparam logic [1:0] CFG_FIRST_BITS       = 2'd0;
    localparam logic [1:0] CFG_SECOND_BITS      = 2'd1;
    localparam logic [1:0] CFG_FIRST_SCENARIOS  = 2'd2;
    localparam logic [1:0] CFG_SECOND_SCENARIOS = 2'd3;

    localparam logic [5:0] RST_FIRST_BITS       = 6'd24;
    localparam logic [5:0] RST_SECOND_BITS      = 6'd16;
    localparam logic [4:0] RST_FIRST_SCENARIOS  = 5'd6;
    localparam logic [4:0] RST_SECOND_SCENARIOS = 5'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_CNT,
        ST_TK_SLOT,
        ST_TK_PAT,
        ST_SHIFT
    } seq_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [5:0]  count0;
        logic [5:0]  count1;
    } frame_load_t;

endpackage

@@ design/lpss_shifter.sv @@
`timescale 1ns / 1ps
// Frame serialiser: sends the low bits of two words LSB first through an output register.
// Depends on lpss_pkg.
module lpss_shifter
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpss_pkg::frame_load_t load,
    output logic                 busy,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [0] serial_bit, [7:1] zero
    output logic                 m_axis_tlast   // latch_bit
);

    logic        active_reg, active_next;
    logic        phase_reg, phase_next;
    logic [5:0]  rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next;
    logic [31:0] word1_reg, word1_next;
    logic [5:0]  cnt1_reg, cnt1_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_bit_reg, out_bit_next;
    logic        out_last_reg, out_last_next;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        word1_reg    <= word1_next;
        cnt1_reg     <= cnt1_next;
        out_bit_reg  <= out_bit_next;
        out_last_reg <= out_last_next;
    end

    assign take = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        active_next    = active_reg;
        phase_next     = phase_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        word1_next     = word1_reg;
        cnt1_next      = cnt1_reg;
        out_valid_next = out_valid_reg;
        out_bit_next   = out_bit_reg;
        out_last_next  = out_last_reg;
        if (load.start)
        begin
            if (take)
            begin
                out_valid_next = 1'b0;
            end
            word1_next = load.word1;
            cnt1_next  = load.count1;
            if (load.count0 != 6'd0)
            begin
                active_next = 1'b1;
                phase_next  = 1'b0;
                rem_next    = load.count0;
                sh_next     = load.word0;
            end
            else if (load.count1 != 6'd0)
            begin
                active_next = 1'b1;
                phase_next  = 1'b1;
                rem_next    = load.count1;
                sh_next     = load.word1;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else if (active_reg && take)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = sh_reg[0];
            out_last_next  = (rem_reg == 6'd1) && (phase_reg || cnt1_reg == 6'd0);
            sh_next        = {1'b0, sh_reg[31:1]};
            rem_next       = rem_reg - 6'd1;
            if (rem_reg == 6'd1)
            begin
                if (!phase_reg && cnt1_reg != 6'd0)
                begin
                    phase_next = 1'b1;
                    sh_next    = word1_reg;
                    rem_next   = cnt1_reg;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign busy          = active_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_bit_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ design/led_pattern_sequencer_serializer_top.sv @@
`timescale 1ns / 1ps
// LED pattern sequencer and serialiser, top level: scenario and pattern memories, tick sequencer.
// Depends on lpss_pkg and lpss_shifter.
//
// Use: requests enter on the s_axis channel; s_axis_tuser carries the opcode (tick, write
// pattern word, write element and repeat counts), s_axis_tdata the address and data.
// Every tick yields a frame on m_axis, one bit per beat: first_group_bits bits of the first
// group's word, then second_group_bits bits of the second group's word, LSB first; tlast
// marks the latch bit. The user must write the four control registers over the cfg channel
// only while idle; the block itself does not enforce it.
// Sequence: a pattern write is a single memory write; a count write is a read-modify-write
// of the scenario memory. A tick reads the scenario entry and then the pattern word of each
// group in turn, loads the serialiser, sends one bit per cycle when unstalled and returns to
// idle.
// Reset: control registers return to their defaults and a clearing pass zeroes the pattern
// memory, one word per cycle, 2*2**ceil(log2(MAX_SCENARIO_COUNT))*2**ceil(log2(MAX_ELEMENTS))
// words (1024 by default), and the scenario memory with it; no request is taken until it ends.
// Stall: frame bits wait in the output register while m_axis_tready is low; the last bit
// may still be waiting when the next request is taken.
module led_pattern_sequencer_serializer_top
#(
    parameter int MAX_ELEMENTS       = lpss_pkg::MAX_ELEMENTS_DEF,
    parameter int MAX_SCENARIO_COUNT = lpss_pkg::MAX_SCENARIO_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // [0] group_select, [4:1] scenario_index,
                                       // [9:5] element_index, [41:10] pattern_value,
                                       // [47:42] element_total, [55:48] repeat_total
    input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] serial_bit, [7:1] zero
    output logic        m_axis_tlast,  // latch_bit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int ELW        = $clog2(MAX_ELEMENTS);
    localparam int LW         = $clog2(MAX_ELEMENTS + 1);
    localparam int CW         = (MAX_SCENARIO_COUNT > 1) ? $clog2(MAX_SCENARIO_COUNT) : 1;
    localparam int SW         = CW + 1;
    localparam int PW         = SW + ELW;
    localparam int SE_W       = LW + ELW + 16;
    localparam int SLOT_DEPTH = 1 << SW;
    localparam int PAT_DEPTH  = 1 << PW;

    // scenario entry: {length, repeats, element position, repeat position}
    localparam int REP_LO  = 0;
    localparam int EL_LO   = 8;
    localparam int REPS_LO = EL_LO + ELW;
    localparam int LEN_LO  = REPS_LO + 8;

    logic [31:0]   pattern_mem [PAT_DEPTH];
    logic [SE_W-1:0] slot_mem  [SLOT_DEPTH];

    lpss_pkg::seq_state_t state_reg, state_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic          grp_reg, grp_next;
    logic [CW-1:0] cur_reg [2];
    logic [CW-1:0] cur_next [2];
    logic [SW-1:0] slot_addr_reg, slot_addr_next;
    logic [LW-1:0] len_hold_reg, len_hold_next;
    logic [7:0]    reps_hold_reg, reps_hold_next;
    logic [31:0]   word0_reg, word0_next;

    logic [5:0]    first_bits_reg, second_bits_reg;
    logic [4:0]    first_scen_reg, second_scen_reg;

    logic          pat_we;
    logic [PW-1:0] pat_waddr, pat_raddr;
    logic [31:0]   pat_wdata, pat_rdata_reg;
    logic          slot_we;
    logic [SW-1:0] slot_waddr, slot_raddr;
    logic [SE_W-1:0] slot_wdata, slot_rdata_reg;

    logic          in_fire;
    logic          in_group;
    logic [6:0]    in_scen, in_elem, in_etot;
    logic [31:0]   in_pval;
    logic [7:0]    in_rtot;
    logic          addr_ok, elem_ok;

    logic [LW-1:0]  rd_len;
    logic [7:0]     rd_reps;
    logic [ELW-1:0] rd_el;
    logic [7:0]     rd_rep;
    logic [6:0]     el_inc;
    logic           el_wrap;
    logic [ELW-1:0] el_new;
    logic [8:0]     rep_inc;
    logic           rep_wrap;
    logic [7:0]     rep_new;
    logic [6:0]     cur_inc;
    logic [6:0]     scen_cnt;
    logic [4:0]     scen_raw;
    logic [CW-1:0]  cur_new;

    lpss_pkg::frame_load_t load;
    logic          shift_busy;

    assign in_group = s_axis_tdata[0];
    assign in_scen  = 7'(s_axis_tdata[4:1]);
    assign in_elem  = 7'(s_axis_tdata[9:5]);
    assign in_pval  = s_axis_tdata[41:10];
    assign in_etot  = 7'(s_axis_tdata[47:42]);
    assign in_rtot  = s_axis_tdata[55:48];
    assign addr_ok  = in_scen < 7'(MAX_SCENARIO_COUNT);
    assign elem_ok  = in_elem < 7'(MAX_ELEMENTS);

    assign s_axis_tready = (state_reg == lpss_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bits_reg  <= lpss_pkg::RST_FIRST_BITS;
            second_bits_reg <= lpss_pkg::RST_SECOND_BITS;
            first_scen_reg  <= lpss_pkg::RST_FIRST_SCENARIOS;
            second_scen_reg <= lpss_pkg::RST_SECOND_SCENARIOS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lpss_pkg::CFG_FIRST_BITS:       first_bits_reg  <= cfg_data;
                lpss_pkg::CFG_SECOND_BITS:      second_bits_reg <= cfg_data;
                lpss_pkg::CFG_FIRST_SCENARIOS:  first_scen_reg  <= cfg_data[4:0];
                lpss_pkg::CFG_SECOND_SCENARIOS: second_scen_reg <= cfg_data[4:0];
                default:                        first_bits_reg  <= first_bits_reg;
            endcase
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pattern_mem[pat_waddr] <= pat_wdata;
        end
        pat_rdata_reg <= pattern_mem[pat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    // counter update for the entry just read
    assign rd_len   = slot_rdata_reg[LEN_LO +: LW];
    assign rd_reps  = slot_rdata_reg[REPS_LO +: 8];
    assign rd_el    = slot_rdata_reg[EL_LO +: ELW];
    assign rd_rep   = slot_rdata_reg[REP_LO +: 8];
    assign el_inc   = 7'(rd_el) + 7'd1;
    assign el_wrap  = el_inc >= 7'(rd_len);
    assign el_new   = el_wrap ? '0 : el_inc[ELW-1:0];
    assign rep_inc  = 9'(rd_rep) + 9'(el_wrap);
    assign rep_wrap = rep_inc >= 9'(rd_reps);
    assign rep_new  = rep_wrap ? 8'd0 : rep_inc[7:0];
    assign cur_inc  = 7'(cur_reg[grp_reg]) + 7'(rep_wrap);
    assign scen_raw = grp_reg ? second_scen_reg : first_scen_reg;

    always_comb
    begin
        if (scen_raw == 5'd0)
        begin
            scen_cnt = 7'd1;
        end
        else if (7'(scen_raw) > 7'(MAX_SCENARIO_COUNT))
        begin
            scen_cnt = 7'(MAX_SCENARIO_COUNT);
        end
        else
        begin
            scen_cnt = 7'(scen_raw);
        end
    end

    assign cur_new = (cur_inc >= scen_cnt) ? '0 : cur_inc[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lpss_pkg::ST_CLEAR;
            clr_reg    <= '0;
            grp_reg    <= 1'b0;
            cur_reg[0] <= '0;
            cur_reg[1] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            grp_reg    <= grp_next;
            cur_reg[0] <= cur_next[0];
            cur_reg[1] <= cur_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        slot_addr_reg <= slot_addr_next;
        len_hold_reg  <= len_hold_next;
        reps_hold_reg <= reps_hold_next;
        word0_reg     <= word0_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        grp_next       = grp_reg;
        cur_next[0]    = cur_reg[0];
        cur_next[1]    = cur_reg[1];
        slot_addr_next = slot_addr_reg;
        len_hold_next  = len_hold_reg;
        reps_hold_next = reps_hold_reg;
        word0_next     = word0_reg;
        pat_we         = 1'b0;
        pat_waddr      = {in_group, in_scen[CW-1:0], in_elem[ELW-1:0]};
        pat_wdata      = in_pval;
        pat_raddr      = {slot_addr_reg, rd_el};
        slot_we        = 1'b0;
        slot_waddr     = slot_addr_reg;
        slot_wdata     = {rd_len, rd_reps, el_new, rep_new};
        slot_raddr     = {in_group, in_scen[CW-1:0]};
        load.start     = 1'b0;
        load.word0     = word0_reg;
        load.word1     = pat_rdata_reg;
        load.count0    = (first_bits_reg > 6'd32) ? 6'd32 : first_bits_reg;
        load.count1    = (second_bits_reg > 6'd32) ? 6'd32 : second_bits_reg;
        case (state_reg)
            lpss_pkg::ST_CLEAR:
            begin
                pat_we     = 1'b1;
                pat_waddr  = clr_reg;
                pat_wdata  = '0;
                slot_we    = (clr_reg[PW-1:SW] == '0);
                slot_waddr = clr_reg[SW-1:0];
                slot_wdata = '0;
                clr_next   = clr_reg + PW'(1);
                if (clr_reg == PW'(PAT_DEPTH - 1))
                begin
                    state_next = lpss_pkg::ST_IDLE;
                end
            end
            lpss_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_axis_tuser)
                        lpss_pkg::OP_WR_PATTERN:
                        begin
                            pat_we = addr_ok && elem_ok;
                        end
                        lpss_pkg::OP_WR_COUNTS:
                        begin
                            if (addr_ok)
                            begin
                                slot_addr_next = {in_group, in_scen[CW-1:0]};
                                len_hold_next  = (in_etot > 7'(MAX_ELEMENTS))
                                               ? LW'(MAX_ELEMENTS) : in_etot[LW-1:0];
                                reps_hold_next = in_rtot;
                                state_next     = lpss_pkg::ST_WR_CNT;
                            end
                        end
                        lpss_pkg::OP_TICK:
                        begin
                            grp_next       = 1'b0;
                            slot_raddr     = {1'b0, cur_reg[0]};
                            slot_addr_next = {1'b0, cur_reg[0]};
                            state_next     = lpss_pkg::ST_TK_SLOT;
                        end
                        default:
                        begin
                            state_next = lpss_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lpss_pkg::ST_WR_CNT:
            begin
                slot_we    = 1'b1;
                slot_wdata = {len_hold_reg, reps_hold_reg, rd_el, rd_rep};
                state_next = lpss_pkg::ST_IDLE;
            end
            lpss_pkg::ST_TK_SLOT:
            begin
                slot_we           = 1'b1;
                cur_next[grp_reg] = cur_new;
                state_next        = lpss_pkg::ST_TK_PAT;
            end
            lpss_pkg::ST_TK_PAT:
            begin
                if (!grp_reg)
                begin
                    word0_next     = pat_rdata_reg;
                    grp_next       = 1'b1;
                    slot_raddr     = {1'b1, cur_reg[1]};
                    slot_addr_next = {1'b1, cur_reg[1]};
                    state_next     = lpss_pkg::ST_TK_SLOT;
                end
                else
                begin
                    load.start = 1'b1;
                    state_next = lpss_pkg::ST_SHIFT;
                end
            end
            lpss_pkg::ST_SHIFT:
            begin
                if (!shift_busy)
                begin
                    state_next = lpss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpss_pkg::ST_IDLE;
            end
        endcase
    end

    lpss_shifter u_shifter
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .busy          (shift_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_busy_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        shift_busy |-> state_reg == lpss_pkg::ST_SHIFT)
        else $error("serialiser active outside the shift phase");

    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lpss_pkg::ST_CLEAR |-> !m_axis_tvalid && !shift_busy)
        else $error("output activity during clearing pass");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

endmodule

@@ sim/tb_led_pattern_sequencer_serializer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for led_pattern_sequencer_serializer_top: directed and random requests,
// a frame predictor in a scoreboard class, random idling on both streams. Depends on lpss_pkg.
module tb_led_pattern_sequencer_serializer_top;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int GROUP_SLOTS  = lpss_pkg::MAX_SCENARIO_COUNT_DEF;
    localparam int SLOT_WORDS   = lpss_pkg::MAX_ELEMENTS_DEF;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic serial;
        logic latch;
    } frame_bit_t;

    class led_frame_scoreboard;
        logic [31:0] pattern_mem [0:2*GROUP_SLOTS*SLOT_WORDS-1];
        int          seg_len [0:2*GROUP_SLOTS-1];
        int          seg_rep [0:2*GROUP_SLOTS-1];
        int          el_pos [0:2*GROUP_SLOTS-1];
        int          rep_pos [0:2*GROUP_SLOTS-1];
        int          cur_scen [0:1];
        int          bits_reg [0:1];
        int          scen_reg [0:1];
        frame_bit_t  frame_bits [$];
        int          errors;

        function new();
            foreach (pattern_mem[i]) pattern_mem[i] = '0;
            foreach (seg_len[i])
            begin
                seg_len[i] = 0;
                seg_rep[i] = 0;
                el_pos[i]  = 0;
                rep_pos[i] = 0;
            end
            cur_scen[0] = 0;
            cur_scen[1] = 0;
            bits_reg[0] = int'(lpss_pkg::RST_FIRST_BITS);
            bits_reg[1] = int'(lpss_pkg::RST_SECOND_BITS);
            scen_reg[0] = int'(lpss_pkg::RST_FIRST_SCENARIOS);
            scen_reg[1] = int'(lpss_pkg::RST_SECOND_SCENARIOS);
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            if (errors < 100)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return frame_bits.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [5:0] val);
            case (idx)
                lpss_pkg::CFG_FIRST_BITS:       bits_reg[0] = int'(val);
                lpss_pkg::CFG_SECOND_BITS:      bits_reg[1] = int'(val);
                lpss_pkg::CFG_FIRST_SCENARIOS:  scen_reg[0] = int'(val[4:0]);
                lpss_pkg::CFG_SECOND_SCENARIOS: scen_reg[1] = int'(val[4:0]);
                default: ;
            endcase
        endfunction

        function logic [31:0] step_group(int g);
            int          cur;
            int          slot;
            int          el;
            int          rep;
            int          sc;
            logic [31:0] word;
            cur  = cur_scen[g];
            slot = g * GROUP_SLOTS + cur;
            el   = el_pos[slot];
            rep  = rep_pos[slot];
            word = pattern_mem[slot * SLOT_WORDS + el];
            sc   = (scen_reg[g] > GROUP_SLOTS) ? GROUP_SLOTS : scen_reg[g];
            el++;
            if (el >= seg_len[slot])
            begin
                el = 0;
                rep++;
            end
            if (rep >= seg_rep[slot])
            begin
                rep = 0;
                cur++;
            end
            if (cur >= sc)
                cur = 0;
            el_pos[slot]  = el;
            rep_pos[slot] = rep;
            cur_scen[g]   = cur;
            return word;
        endfunction

        function void note_request(logic [1:0] op, logic [55:0] d);
            int          slot;
            int          n0;
            int          n1;
            int          total;
            logic [31:0] w0;
            logic [31:0] w1;
            frame_bit_t  fb;
            if (op == lpss_pkg::OP_WR_PATTERN || op == lpss_pkg::OP_WR_COUNTS)
            begin
                slot = int'(d[0]) * GROUP_SLOTS + int'(d[4:1]);
                if (op == lpss_pkg::OP_WR_PATTERN)
                    pattern_mem[slot * SLOT_WORDS + int'(d[9:5])] = d[41:10];
                else
                begin
                    seg_len[slot] = (d[47:42] > SLOT_WORDS) ? SLOT_WORDS : int'(d[47:42]);
                    seg_rep[slot] = int'(d[55:48]);
                end
            end
            else if (op == lpss_pkg::OP_TICK)
            begin
                w0    = step_group(0);
                w1    = step_group(1);
                n0    = (bits_reg[0] > 32) ? 32 : bits_reg[0];
                n1    = (bits_reg[1] > 32) ? 32 : bits_reg[1];
                total = n0 + n1;
                for (int k = 0; k < n0; k++)
                begin
                    fb.serial = w0[k];
                    fb.latch  = (k == total - 1);
                    frame_bits.push_back(fb);
                end
                for (int k = 0; k < n1; k++)
                begin
                    fb.serial = w1[k];
                    fb.latch  = (n0 + k == total - 1);
                    frame_bits.push_back(fb);
                end
            end
        endfunction

        task check_bit(logic serial, logic latch);
            frame_bit_t fb;
            if (frame_bits.size() == 0)
                report_mismatch($sformatf("unexpected bit %b last %b", serial, latch));
            else
            begin
                fb = frame_bits.pop_front();
                if (serial !== fb.serial)
                    report_mismatch($sformatf("serial_bit %b, want %b", serial, fb.serial));
                if (latch !== fb.latch)
                    report_mismatch($sformatf("latch_bit %b, want %b", latch, fb.latch));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data = '0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;

    led_frame_scoreboard sb = new();

    led_pattern_sequencer_serializer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_bit(m_axis_tdata[0], m_axis_tlast);
        end
    end

    function automatic logic [55:0] pack_request(logic g, logic [3:0] s, logic [4:0] e,
                                                 logic [31:0] v, logic [5:0] et,
                                                 logic [7:0] rt);
        return {rt, et, v, e, s, g};
    endfunction

    task send_request(logic [1:0] op, logic [55:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(op, d);
    endtask

    task send_tick();
        send_request(lpss_pkg::OP_TICK, 56'({$urandom, $urandom}));
    endtask

    task write_register(logic [1:0] idx, logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, val);
    endtask

    task drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task send_random();
        int          r;
        logic [1:0]  op;
        logic [3:0]  s;
        logic [4:0]  e;
        logic [5:0]  et;
        logic [7:0]  rt;
        r  = $urandom_range(99);
        op = (r < 40) ? lpss_pkg::OP_TICK
           : (r < 70) ? lpss_pkg::OP_WR_PATTERN
           : (r < 95) ? lpss_pkg::OP_WR_COUNTS : OP_UNUSED;
        s  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
        e  = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(3));
        et = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(4, 1));
        rt = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        send_request(op, pack_request(1'($urandom_range(1)), s, e, $urandom, et, rt));
    endtask

    task run_phase(logic [5:0] b0, logic [5:0] b1, logic [5:0] s0, logic [5:0] s1,
                   int idle, int stall, int count, bit hold);
        drain();
        write_register(lpss_pkg::CFG_FIRST_BITS, b0);
        write_register(lpss_pkg::CFG_SECOND_BITS, b1);
        write_register(lpss_pkg::CFG_FIRST_SCENARIOS, s0);
        write_register(lpss_pkg::CFG_SECOND_SCENARIOS, s1);
        cfg_valid      <= 1'b0;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (hold)
            hold_req = 1'b1;
        repeat (count) send_random();
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        int wait_cnt;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes, saturated count, zero counts, unused opcode, stale counters
        send_tick();
        send_request(lpss_pkg::OP_WR_COUNTS,
                     pack_request(1'b0, 4'd0,  5'd0,  '0, 6'd3,  8'd2));
        send_request(lpss_pkg::OP_WR_COUNTS,
                     pack_request(1'b1, 4'd0,  5'd0,  '0, 6'd63, 8'd255));
        send_request(lpss_pkg::OP_WR_PATTERN,
                     pack_request(1'b0, 4'd0,  5'd0,  32'hFFFF_FFFF, '0, '0));
        send_request(lpss_pkg::OP_WR_PATTERN,
                     pack_request(1'b0, 4'd0,  5'd1,  32'h0000_0001, '0, '0));
        send_request(lpss_pkg::OP_WR_PATTERN,
                     pack_request(1'b0, 4'd0,  5'd2,  32'h8000_0000, '0, '0));
        send_request(lpss_pkg::OP_WR_PATTERN,
                     pack_request(1'b1, 4'd0,  5'd31, 32'hA5A5_A5A5, '0, '0));
        send_request(lpss_pkg::OP_WR_PATTERN,
                     pack_request(1'b1, 4'd0,  5'd0,  32'h5A5A_5A5A, '0, '0));
        send_request(lpss_pkg::OP_WR_PATTERN,
                     pack_request(1'b1, 4'd15, 5'd31, 32'h0000_0000, '0, '0));
        send_request(OP_UNUSED, {8'hFF, 6'h3F, 32'hFFFF_FFFF, 5'h1F, 4'hF, 1'b1});
        send_request(lpss_pkg::OP_WR_COUNTS,
                     pack_request(1'b0, 4'd1,  5'd0,  '0, 6'd0,  8'd0));
        send_request(lpss_pkg::OP_WR_COUNTS,
                     pack_request(1'b1, 4'd15, 5'd31, '0, 6'd32, 8'd1));
        repeat (6) send_tick();
        send_request(lpss_pkg::OP_WR_COUNTS,
                     pack_request(1'b0, 4'd0,  5'd0,  '0, 6'd1,  8'd1));
        repeat (4) send_tick();
        s_axis_tvalid <= 1'b0;

        run_phase(6'd32, 6'd32, 6'd16, 6'd16, 0, 0, 25, 1'b1);
        run_phase(6'd1, 6'd1, 6'd1, 6'd1, 61, 0, 25, 1'b0);
        run_phase(6'd63, 6'd0, 6'd31, 6'd0, 0, 61, 25, 1'b0);
        run_phase(6'd0, 6'd0, 6'd2, 6'd3, 8, 8, 10, 1'b0);
        run_phase(6'($urandom_range(63)), 6'($urandom_range(33, 1)), 6'($urandom_range(31)),
                  6'($urandom_range(17, 1)), 8, 8, 25, 1'b0);
        run_phase(lpss_pkg::RST_FIRST_BITS, lpss_pkg::RST_SECOND_BITS,
                  6'(lpss_pkg::RST_FIRST_SCENARIOS), 6'(lpss_pkg::RST_SECOND_SCENARIOS),
                  0, 0, 20, 1'b0);

        wait_cnt = 0;
        while (sb.pending() != 0 && wait_cnt < 50_000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d frame bits never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
